[rtl/bthp_pkg.sv]
// Shared types and constants for the BER tag and length header parser.
`default_nettype none

package bthp_pkg;

  localparam logic [4:0] LOW_TAG_LONG = 5'h1F;
  localparam logic [6:0] GROUP_MASK = 7'h7F;
  localparam logic [1:0] MAX_TAG_BYTES = 2'd3;
  localparam logic [6:0] MAX_LEN_BYTES = 7'd4;
  localparam logic [31:0] MAX_SIZE_RESET = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_HEADER = 3'd1,
    ST_BAD_LENGTH = 3'd2,
    ST_OVER_MAX   = 3'd3,
    ST_BAD_OFFSET = 3'd4
  } bthp_status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
    logic       last_in_buffer;
  } bthp_in_t;

  typedef struct packed {
    logic [7:0]  first_byte;
    logic [20:0] tag_number;
    logic [31:0] content_length;
    logic        indefinite;
    logic [3:0]  header_size;
    logic [2:0]  status;
  } bthp_out_t;

endpackage

`default_nettype wire

[rtl/bthp_in_reg.sv]
// Input register that holds one request until the decoder takes it.
`default_nettype none

module bthp_in_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire bthp_pkg::bthp_in_t in_data,
  input  wire logic              take_i,
  output logic                   vld_o,
  output bthp_pkg::bthp_in_t     data_o
);

  logic               vld_r;
  logic               vld_nxt;
  bthp_pkg::bthp_in_t data_r;
  logic               load;

  assign in_stall = vld_r && !take_i;
  assign load     = in_valid && !in_stall;

  always_comb begin
    if (load) begin
      vld_nxt = 1'b1;
    end else if (take_i) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_data;
    end
  end

  assign vld_o  = vld_r;
  assign data_o = data_r;

endmodule

`default_nettype wire

[rtl/bthp_decode.sv]
// Header state machine that advances on one byte per step and builds the result.
`default_nettype none

module bthp_decode (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [31:0]        cfg_wr_data,
  input  wire logic               go_i,
  input  wire bthp_pkg::bthp_in_t req_i,
  output logic                    emit_o,
  output bthp_pkg::bthp_out_t     res_o
);

  typedef enum logic [1:0] {
    PH_IDENT = 2'd0,
    PH_TAG   = 2'd1,
    PH_LEN0  = 2'd2,
    PH_LENN  = 2'd3
  } phase_t;

  phase_t      phase_r, phase_nxt, phase_cur;
  logic [1:0]  tseen_r, tseen_nxt;
  logic [20:0] tacc_r, tacc_nxt;
  logic [7:0]  fbh_r, fbh_nxt;
  logic [31:0] lacc_r, lacc_nxt;
  logic [2:0]  lleft_r, lleft_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [31:0] max_size_r;

  logic [7:0]  b;
  logic        emit;
  bthp_pkg::bthp_status_t st;
  logic [31:0] len;
  logic        indef;

  always_comb begin
    b         = req_i.data_byte;
    phase_cur = req_i.start_req ? PH_IDENT : phase_r;
    phase_nxt = phase_cur;
    tseen_nxt = tseen_r;
    tacc_nxt  = tacc_r;
    fbh_nxt   = fbh_r;
    lacc_nxt  = lacc_r;
    lleft_nxt = lleft_r;
    cnt_nxt   = cnt_r + 4'd1;
    emit      = 1'b0;
    st        = bthp_pkg::ST_OK;
    len       = 32'd0;
    indef     = 1'b0;

    unique case (phase_cur)
      PH_IDENT: begin
        fbh_nxt   = b;
        cnt_nxt   = 4'd1;
        tseen_nxt = 2'd0;
        lacc_nxt  = 32'd0;
        lleft_nxt = 3'd0;
        if (b[4:0] == bthp_pkg::LOW_TAG_LONG) begin
          tacc_nxt  = 21'd0;
          phase_nxt = PH_TAG;
        end else begin
          tacc_nxt  = {16'd0, b[4:0]};
          phase_nxt = PH_LEN0;
        end
        if (req_i.last_in_buffer) begin
          emit = 1'b1;
          st   = bthp_pkg::ST_BAD_OFFSET;
        end
      end
      PH_TAG: begin
        if (tseen_r == bthp_pkg::MAX_TAG_BYTES) begin
          emit = 1'b1;
          st   = bthp_pkg::ST_BAD_HEADER;
        end else begin
          tacc_nxt  = {tacc_r[13:0], b[6:0] & bthp_pkg::GROUP_MASK};
          tseen_nxt = tseen_r + 2'd1;
          if (!b[7]) begin
            phase_nxt = PH_LEN0;
          end
          if (req_i.last_in_buffer) begin
            emit = 1'b1;
            st   = bthp_pkg::ST_BAD_OFFSET;
          end
        end
      end
      PH_LEN0: begin
        if (!b[7]) begin
          emit = 1'b1;
          len  = {24'd0, b};
        end else if ((b[6:0] & bthp_pkg::GROUP_MASK) > bthp_pkg::MAX_LEN_BYTES) begin
          emit = 1'b1;
          st   = bthp_pkg::ST_BAD_LENGTH;
        end else if (b[6:0] == 7'd0) begin
          emit  = 1'b1;
          indef = 1'b1;
        end else begin
          lacc_nxt  = 32'd0;
          lleft_nxt = b[2:0];
          phase_nxt = PH_LENN;
          if (req_i.last_in_buffer) begin
            emit = 1'b1;
            st   = bthp_pkg::ST_BAD_OFFSET;
          end
        end
      end
      PH_LENN: begin
        lacc_nxt = {lacc_r[23:0], b};
        if (lleft_r != 3'd0) begin
          lleft_nxt = lleft_r - 3'd1;
        end
        if (lleft_nxt == 3'd0) begin
          emit = 1'b1;
          if (lacc_nxt > max_size_r) begin
            st = bthp_pkg::ST_OVER_MAX;
          end else begin
            len = lacc_nxt;
          end
        end else if (req_i.last_in_buffer) begin
          emit = 1'b1;
          st   = bthp_pkg::ST_BAD_OFFSET;
        end
      end
      default: begin
        phase_nxt = PH_IDENT;
      end
    endcase

    if (emit) begin
      phase_nxt = PH_IDENT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDENT;
      tseen_r    <= 2'd0;
      tacc_r     <= 21'd0;
      fbh_r      <= 8'd0;
      lacc_r     <= 32'd0;
      lleft_r    <= 3'd0;
      cnt_r      <= 4'd0;
      max_size_r <= bthp_pkg::MAX_SIZE_RESET;
    end else begin
      if (cfg_wr_en) begin
        max_size_r <= cfg_wr_data;
      end
      if (go_i) begin
        phase_r <= phase_nxt;
        tseen_r <= tseen_nxt;
        tacc_r  <= tacc_nxt;
        fbh_r   <= fbh_nxt;
        lacc_r  <= lacc_nxt;
        lleft_r <= lleft_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  assign emit_o = go_i && emit;

  always_comb begin
    res_o.first_byte     = fbh_nxt;
    res_o.tag_number     = tacc_nxt;
    res_o.content_length = (st == bthp_pkg::ST_OK) ? len : 32'd0;
    res_o.indefinite     = (st == bthp_pkg::ST_OK) ? indef : 1'b0;
    res_o.header_size    = cnt_nxt;
    res_o.status         = st;
  end

endmodule

`default_nettype wire

[rtl/bthp_out_buf.sv]
// Two-entry result buffer that keeps the decoder running while the sink stalls, until it is full.
`default_nettype none

module bthp_out_buf (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push_i,
  input  wire bthp_pkg::bthp_out_t data_i,
  output logic                     full_o,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output bthp_pkg::bthp_out_t      out_data
);

  bthp_pkg::bthp_out_t mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign full_o    = (cnt_r == 2'd2);
  assign pop       = out_valid && !out_stall;
  assign out_data  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_i && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push_i) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push_i) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/ber_tlv_header_parser_unit.sv]
// Top level of the BER tag and length header parser.
// A header's last or failing byte is held in the input register, its result in the result buffer.
// Throughput: one byte per cycle unless the result buffer is full; the decode is combinational.
// The two-entry result buffer lets decoding go on while the sink stalls, until both entries are full.
// Reset is synchronous and active low; it clears the state machine and buffers and sets
// max_size to all ones.
`default_nettype none

module ber_tlv_header_parser_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire bthp_pkg::bthp_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output bthp_pkg::bthp_out_t      out_data,
  input  wire logic                cfg_wr_en,
  input  wire logic [31:0]         cfg_wr_data
);

  logic                req_vld;
  bthp_pkg::bthp_in_t  req;
  logic                go;
  logic                emit;
  bthp_pkg::bthp_out_t res;
  logic                buf_full;

  assign go = req_vld && !buf_full;

  bthp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .take_i   (go),
    .vld_o    (req_vld),
    .data_o   (req)
  );

  bthp_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .go_i        (go),
    .req_i       (req),
    .emit_o      (emit),
    .res_o       (res)
  );

  bthp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_i    (emit),
    .data_i    (res),
    .full_o    (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[rtl/bthp_checker.sv]
// Port-level checks for the header parser and the bind that attaches them.
`default_nettype none

module bthp_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire bthp_pkg::bthp_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result changed or was dropped.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result shown right after reset.");

  a_indef_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.indefinite |->
      out_data.content_length == 32'd0 && out_data.status == bthp_pkg::ST_OK)
    else $error("Indefinite result carries a length or an error.");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != bthp_pkg::ST_OK |->
      out_data.content_length == 32'd0 && !out_data.indefinite)
    else $error("Failed header reports a length.");

  a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.header_size >= 4'd1 && out_data.header_size <= 4'd9)
    else $error("Header size out of range.");

endmodule

bind ber_tlv_header_parser_unit bthp_checker u_bthp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
